/* src/wems_pkg.sv */
// shared constants and types for the window edge magnet snap unit
`default_nettype none
package wems_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF  = 4;

   localparam int ACT_BITS       = 3;
   localparam int CSR_IDX_BITS   = 3;
   localparam int SNAP_BITS      = 12;
   localparam int SIZE_CFG_BITS  = 23;
   localparam int CSR_DATA_BITS  = 23;

   localparam logic [ACT_BITS-1:0] ACT_BEGIN     = 3'd0;
   localparam logic [ACT_BITS-1:0] ACT_CURRENT   = 3'd1;
   localparam logic [ACT_BITS-1:0] ACT_CONTAIN   = 3'd2;
   localparam logic [ACT_BITS-1:0] ACT_NEIGHBOUR = 3'd3;
   localparam logic [ACT_BITS-1:0] ACT_FINISH    = 3'd4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SNAP_DIST = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BORDER    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_W     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_H     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_W     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_H     = 3'd5;

   localparam logic [SNAP_BITS-1:0]     SNAP_DIST_RST = 12'd128;
   localparam logic [SNAP_BITS-1:0]     BORDER_RST    = 12'd0;
   localparam logic [SIZE_CFG_BITS-1:0] MIN_SIZE_RST  = 23'd16;
   localparam logic [SIZE_CFG_BITS-1:0] MAX_SIZE_RST  = 23'h7FFFFF;

   typedef struct packed {
      logic [SNAP_BITS-1:0]     snap;
      logic [SNAP_BITS-1:0]     border;
      logic [SIZE_CFG_BITS-1:0] min_w;
      logic [SIZE_CFG_BITS-1:0] min_h;
      logic [SIZE_CFG_BITS-1:0] max_w;
      logic [SIZE_CFG_BITS-1:0] max_h;
   } cfg_type;

endpackage
`default_nettype wire

/* src/wems_engine.sv */
// snap state and per-item update logic, plus the finish result
`default_nettype none
module wems_engine
   import wems_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         item_valid,
   input  wire logic [ACT_BITS-1:0]          item_action,
   input  wire logic signed [COORD_BITS-1:0] item_x,
   input  wire logic signed [COORD_BITS-1:0] item_y,
   input  wire logic [COORD_BITS-2:0]        item_w,
   input  wire logic [COORD_BITS-2:0]        item_h,
   input  wire logic                         item_resize,
   input  wire cfg_type                      cfg,
   output logic                              res_emit,
   output logic signed [COORD_BITS-1:0]      res_x,
   output logic signed [COORD_BITS-1:0]      res_y,
   output logic [COORD_BITS-2:0]             res_w,
   output logic [COORD_BITS-2:0]             res_h,
   output logic                              res_moved
);

   // wide enough that grown and pulled boxes never wrap
   localparam int W = ((COORD_BITS > SIZE_CFG_BITS + 1) ? COORD_BITS : SIZE_CFG_BITS + 1) + 4;

   typedef logic signed [W-1:0] val_type;
   typedef struct packed {
      val_type x;
      val_type y;
      val_type w;
      val_type h;
   } box_type;

   function automatic val_type absw(input val_type v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic val_type satw(input val_type v, input val_type lo, input val_type hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic earlier(input box_type a, input box_type b);
      if (a.x != b.x) return a.x < b.x;
      if (a.y != b.y) return a.y < b.y;
      if (a.w != b.w) return a.w < b.w;
      return a.h < b.h;
   endfunction

   // move-mode pull of one axis toward the inside of a containing box
   function automatic val_type ins_axis(input val_type pos, input val_type len,
                                        input val_type lo, input val_type ext,
                                        input val_type d);
      logic    found;
      val_type bd;
      val_type v;
      val_type sep;
      found = (pos > lo) && (pos - lo < d);
      bd    = pos - lo;
      v     = found ? lo : pos;
      sep   = absw((lo + ext) - (pos + len));
      if (sep < d && (!found || sep < bd)) v = lo + ext - len;
      return v;
   endfunction

   logic    mode_ff, mode_in;
   logic [3:0] edges_ff, edges_in;
   logic [3:0] found_ff, found_in;
   box_type begin_ff, begin_in;
   box_type orig_ff, orig_in;
   box_type work_ff, work_in;
   val_type bdist_ff [4];
   val_type bdist_in [4];
   val_type bval_ff [4];
   val_type bval_in [4];
   box_type bkey_ff [4];
   box_type bkey_in [4];

   box_type in_box, nb_box;
   val_type bw, d;
   logic    cand_ok  [4];
   val_type cand_val [4];
   val_type cand_cur [4];

   always_comb begin
      in_box.x = val_type'($signed(item_x));
      in_box.y = val_type'($signed(item_y));
      in_box.w = val_type'({1'b0, item_w});
      in_box.h = val_type'({1'b0, item_h});
      bw       = val_type'({1'b0, cfg.border});
      d        = val_type'({1'b0, cfg.snap});
      nb_box.x = in_box.x - bw;
      nb_box.y = in_box.y - bw;
      nb_box.w = in_box.w + (bw <<< 1);
      nb_box.h = in_box.h + (bw <<< 1);
   end

   // neighbour candidates, one per slot
   always_comb begin
      val_type orr, obt, gr, gb;
      logic    xa, xb, ya, yb;
      orr = nb_box.x + nb_box.w;
      obt = nb_box.y + nb_box.h;
      gr  = work_ff.x + work_ff.w;
      gb  = work_ff.y + work_ff.h;
      xa  = (work_ff.x > orr) && (work_ff.x < orr + d);
      xb  = (gr < nb_box.x) && (gr > nb_box.x - d);
      ya  = (work_ff.y > obt) && (work_ff.y < obt + d);
      yb  = (gb < nb_box.y) && (gb > nb_box.y - d);
      if (!mode_ff) begin
         cand_ok[0]  = xa || xb;
         cand_val[0] = xa ? orr : nb_box.x - work_ff.w;
         cand_cur[0] = work_ff.x;
         cand_ok[1]  = ya || yb;
         cand_val[1] = ya ? obt : nb_box.y - work_ff.h;
         cand_cur[1] = work_ff.y;
         cand_ok[2]  = 1'b0;
         cand_val[2] = orr;
         cand_cur[2] = work_ff.y;
         cand_ok[3]  = 1'b0;
         cand_val[3] = obt;
         cand_cur[3] = work_ff.y;
      end else begin
         cand_ok[0]  = edges_ff[0] && xa;
         cand_val[0] = orr;
         cand_cur[0] = work_ff.x;
         cand_ok[1]  = edges_ff[1] && xb;
         cand_val[1] = nb_box.x - work_ff.w;
         cand_cur[1] = work_ff.x;
         cand_ok[2]  = edges_ff[2] && ya;
         cand_val[2] = obt;
         cand_cur[2] = work_ff.y;
         cand_ok[3]  = edges_ff[3] && yb;
         cand_val[3] = nb_box.y - work_ff.h;
         cand_cur[3] = work_ff.y;
      end
   end

   always_comb begin
      val_type cx, cw, cy, ch, sep;
      mode_in  = mode_ff;
      edges_in = edges_ff;
      found_in = found_ff;
      begin_in = begin_ff;
      orig_in  = orig_ff;
      work_in  = work_ff;
      for (int i = 0; i < 4; i++) begin
         bdist_in[i] = bdist_ff[i];
         bval_in[i]  = bval_ff[i];
         bkey_in[i]  = bkey_ff[i];
      end
      cx = work_ff.x;
      cw = work_ff.w;
      cy = work_ff.y;
      ch = work_ff.h;
      sep = '0;
      if (item_valid) begin
         case (item_action)
            ACT_BEGIN: begin
               begin_in = in_box;
            end
            ACT_CURRENT: begin
               orig_in   = in_box;
               mode_in   = item_resize;
               work_in.x = in_box.x - bw;
               work_in.y = in_box.y - bw;
               work_in.w = in_box.w + (bw <<< 1);
               work_in.h = in_box.h + (bw <<< 1);
               edges_in[0] = in_box.x != begin_ff.x;
               edges_in[1] = (in_box.x + in_box.w) != (begin_ff.x + begin_ff.w);
               edges_in[2] = in_box.y != begin_ff.y;
               edges_in[3] = (in_box.y + in_box.h) != (begin_ff.y + begin_ff.h);
               found_in = '0;
            end
            ACT_CONTAIN: begin
               if (!mode_ff) begin
                  work_in.x = ins_axis(work_ff.x, work_ff.w, in_box.x, in_box.w, d);
                  work_in.y = ins_axis(work_ff.y, work_ff.h, in_box.y, in_box.h, d);
               end else begin
                  // a left pull keeps the right edge where it was
                  if (edges_ff[0] && absw(cx - in_box.x) < d) begin
                     cw = cw + cx - in_box.x;
                     cx = in_box.x;
                  end
                  if (edges_ff[1] && absw((in_box.x + in_box.w) - (cx + cw)) < d)
                     cw = in_box.x + in_box.w - cx;
                  if (edges_ff[2] && absw(cy - in_box.y) < d) begin
                     ch = ch + cy - in_box.y;
                     cy = in_box.y;
                  end
                  if (edges_ff[3] && absw((in_box.y + in_box.h) - (cy + ch)) < d)
                     ch = in_box.y + in_box.h - cy;
                  work_in.x = cx;
                  work_in.w = cw;
                  work_in.y = cy;
                  work_in.h = ch;
               end
            end
            ACT_NEIGHBOUR: begin
               for (int i = 0; i < 4; i++) begin
                  sep = absw(cand_val[i] - cand_cur[i]);
                  if (cand_ok[i] && sep < d &&
                      (!found_ff[i] || sep < bdist_ff[i] ||
                       (sep == bdist_ff[i] && earlier(nb_box, bkey_ff[i])))) begin
                     found_in[i] = 1'b1;
                     bdist_in[i] = sep;
                     bval_in[i]  = cand_val[i];
                     bkey_in[i]  = nb_box;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         edges_ff <= '0;
         found_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         edges_ff <= edges_in;
         found_ff <= found_in;
      end
      begin_ff <= begin_in;
      orig_ff  <= orig_in;
      work_ff  <= work_in;
      for (int i = 0; i < 4; i++) begin
         bdist_ff[i] <= bdist_in[i];
         bval_ff[i]  <= bval_in[i];
         bkey_ff[i]  <= bkey_in[i];
      end
   end

   // finish result from the collected state
   always_comb begin
      val_type gx, gy, gw, gh, rw, rh, one;
      val_type mnx, mny, mxx, mxy, ox, oy, ow, oh, hi, lo;
      val_type fx, fy, fw, fh;
      one = val_type'(1) <<< FRAC_BITS;
      hi  = (val_type'(1) <<< (COORD_BITS - 1)) - val_type'(1);
      lo  = -hi - val_type'(1);
      gx  = work_ff.x;
      gy  = work_ff.y;
      gw  = work_ff.w;
      gh  = work_ff.h;
      rw  = '0;
      rh  = '0;
      mnx = val_type'({1'b0, cfg.min_w});
      mny = val_type'({1'b0, cfg.min_h});
      if (mnx < one) mnx = one;
      if (mny < one) mny = one;
      mxx = val_type'({1'b0, cfg.max_w});
      mxy = val_type'({1'b0, cfg.max_h});
      if (mxx < mnx) mxx = mnx;
      if (mxy < mny) mxy = mny;
      if (!mode_ff) begin
         if (found_ff[0]) gx = bval_ff[0];
         if (found_ff[1]) gy = bval_ff[1];
         ox = gx + bw;
         oy = gy + bw;
         ow = orig_ff.w;
         oh = orig_ff.h;
      end else if (cfg.snap == '0 || edges_ff == '0) begin
         ox = orig_ff.x;
         oy = orig_ff.y;
         ow = orig_ff.w;
         oh = orig_ff.h;
      end else begin
         if (found_ff[0]) begin
            gw = gw + gx - bval_ff[0];
            gx = bval_ff[0];
         end
         if (found_ff[1]) gw = bval_ff[1] - gx;
         if (found_ff[2]) begin
            gh = gh + gy - bval_ff[2];
            gy = bval_ff[2];
         end
         if (found_ff[3]) gh = bval_ff[3] - gy;
         rw = gw - (bw <<< 1);
         rh = gh - (bw <<< 1);
         ow = satw(rw, mnx, mxx);
         oh = satw(rh, mny, mxy);
         ox = gx + bw;
         oy = gy + bw;
         // a left or top drag keeps the opposite edge fixed under the clamp
         if (edges_ff[0] && !edges_ff[1]) ox = ox + rw - ow;
         if (edges_ff[2] && !edges_ff[3]) oy = oy + rh - oh;
      end
      fx = satw(ox, lo, hi);
      fy = satw(oy, lo, hi);
      fw = satw(ow, '0, hi);
      fh = satw(oh, '0, hi);
      res_x     = fx[COORD_BITS-1:0];
      res_y     = fy[COORD_BITS-1:0];
      res_w     = fw[COORD_BITS-2:0];
      res_h     = fh[COORD_BITS-2:0];
      res_moved = (fx != orig_ff.x) || (fy != orig_ff.y) ||
                  (fw != orig_ff.w) || (fh != orig_ff.h);
      res_emit  = item_valid && (item_action == ACT_FINISH);
   end

endmodule
`default_nettype wire

/* src/window_edge_magnet_snap_unit.sv */
// top level: input register, configuration registers, result register
`default_nettype none
// Snaps a dragged window box to nearby screen, workarea and neighbour edges.
// Send an optional begin box, the current box, containing boxes, neighbours
// and a finish item; finish yields one result. Every item passes through the
// input register and the single-pass snap logic, so one item is accepted
// per clock; a finish stalls only while the result register holds an
// untaken result. The snap logic reads the configuration from its registers.
module window_edge_magnet_snap_unit
   import wems_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [ACT_BITS-1:0]          req_action,
   input  wire logic signed [COORD_BITS-1:0] req_box_x,
   input  wire logic signed [COORD_BITS-1:0] req_box_y,
   input  wire logic [COORD_BITS-2:0]        req_box_w,
   input  wire logic [COORD_BITS-2:0]        req_box_h,
   input  wire logic                         req_resize_drag,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0]      rsp_out_x,
   output logic signed [COORD_BITS-1:0]      rsp_out_y,
   output logic [COORD_BITS-2:0]             rsp_out_w,
   output logic [COORD_BITS-2:0]             rsp_out_h,
   output logic                              rsp_moved,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]      csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]     csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic                         in_valid_ff, in_valid_in;
   logic [ACT_BITS-1:0]          in_action_ff;
   logic signed [COORD_BITS-1:0] in_x_ff, in_y_ff;
   logic [COORD_BITS-2:0]        in_w_ff, in_h_ff;
   logic                         in_resize_ff;
   logic                         advance;

   logic                         emit;
   logic signed [COORD_BITS-1:0] res_x, res_y;
   logic [COORD_BITS-2:0]        res_w, res_h;
   logic                         res_moved;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] out_x_ff, out_y_ff;
   logic [COORD_BITS-2:0]        out_w_ff, out_h_ff;
   logic                         moved_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SNAP_DIST: cfg_in.snap   = csr_wdata[SNAP_BITS-1:0];
            CSR_BORDER:    cfg_in.border = csr_wdata[SNAP_BITS-1:0];
            CSR_MIN_W:     cfg_in.min_w  = csr_wdata[SIZE_CFG_BITS-1:0];
            CSR_MIN_H:     cfg_in.min_h  = csr_wdata[SIZE_CFG_BITS-1:0];
            CSR_MAX_W:     cfg_in.max_w  = csr_wdata[SIZE_CFG_BITS-1:0];
            CSR_MAX_H:     cfg_in.max_h  = csr_wdata[SIZE_CFG_BITS-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // only a finish can wait, and only on a full result register
   assign advance     = !((in_action_ff == ACT_FINISH) && rsp_valid_ff && !rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.snap   <= SNAP_DIST_RST;
         cfg_ff.border <= BORDER_RST;
         cfg_ff.min_w  <= MIN_SIZE_RST;
         cfg_ff.min_h  <= MIN_SIZE_RST;
         cfg_ff.max_w  <= MAX_SIZE_RST;
         cfg_ff.max_h  <= MAX_SIZE_RST;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_x_ff      <= req_box_x;
         in_y_ff      <= req_box_y;
         in_w_ff      <= req_box_w;
         in_h_ff      <= req_box_h;
         in_resize_ff <= req_resize_drag;
      end
      if (emit) begin
         out_x_ff <= res_x;
         out_y_ff <= res_y;
         out_w_ff <= res_w;
         out_h_ff <= res_h;
         moved_ff <= res_moved;
      end
   end

   wems_engine #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (in_valid_ff && advance),
      .item_action (in_action_ff),
      .item_x      (in_x_ff),
      .item_y      (in_y_ff),
      .item_w      (in_w_ff),
      .item_h      (in_h_ff),
      .item_resize (in_resize_ff),
      .cfg         (cfg_ff),
      .res_emit    (emit),
      .res_x       (res_x),
      .res_y       (res_y),
      .res_w       (res_w),
      .res_h       (res_h),
      .res_moved   (res_moved)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;
   assign rsp_out_w = out_w_ff;
   assign rsp_out_h = out_h_ff;
   assign rsp_moved = moved_ff;

`ifndef SYNTH
   a_nonfinish_never_stalls: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_action_ff != ACT_FINISH) |-> advance)
      else $error("non-finish item stalled");

   a_finish_gives_result: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && in_action_ff == ACT_FINISH) |=> rsp_valid_ff)
      else $error("finish transfer produced no result");

   a_ready_when_room: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input blocked with empty result register");
`endif

endmodule
`default_nettype wire

/* tb/window_edge_magnet_snap_unit_tb.sv */
// self-checking testbench for the window edge magnet snap unit
`default_nettype none
module window_edge_magnet_snap_unit_tb;
   import wems_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = COORD_BITS_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam longint HI = (64'sd1 <<< (CB - 1)) - 1;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [ACT_BITS-1:0] ACT_UNUSED = 3'd7;

   typedef struct {
      logic [ACT_BITS-1:0] action;
      logic [CB-1:0]       x;
      logic [CB-1:0]       y;
      logic [CB-2:0]       w;
      logic [CB-2:0]       h;
      logic                rdrag;
   } drag_item_t;

   typedef struct {
      logic [CB-1:0] x;
      logic [CB-1:0] y;
      logic [CB-2:0] w;
      logic [CB-2:0] h;
      logic          moved;
   } snap_box_t;

   typedef struct { longint x, y, w, h; } gbox_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [ACT_BITS-1:0] req_action = '0;
   logic signed [CB-1:0] req_box_x = '0;
   logic signed [CB-1:0] req_box_y = '0;
   logic [CB-2:0] req_box_w = '0;
   logic [CB-2:0] req_box_h = '0;
   logic req_resize_drag = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [CB-1:0] rsp_out_x;
   logic signed [CB-1:0] rsp_out_y;
   logic [CB-2:0] rsp_out_w;
   logic [CB-2:0] rsp_out_h;
   logic rsp_moved;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   window_edge_magnet_snap_unit dut (.*);

   always #2 clock = ~clock;

   // predictor state
   longint snap_d, border, min_w, min_h, max_w, max_h;
   bit     resize_mode;
   gbox_t  begin_b, cur_b, grown_b;
   bit [3:0] edges;
   bit     pick_found [4];
   longint pick_dist [4];
   longint pick_val [4];
   gbox_t  pick_key [4];

   drag_item_t pending_items[$];
   snap_box_t  expected_boxes[$];
   int errors = 0;
   int n_items = 0;
   int n_results = 0;
   int n_moved = 0;
   int idle_cycles = 0;
   bit hold_sender = 1'b0;

   function automatic void add_item(drag_item_t it);
      pending_items.insert(pending_items.size(), it);
   endfunction

   function automatic longint labs(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint clampv(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic bit key_earlier(gbox_t a, gbox_t b);
      if (a.x != b.x) return a.x < b.x;
      if (a.y != b.y) return a.y < b.y;
      if (a.w != b.w) return a.w < b.w;
      return a.h < b.h;
   endfunction

   task automatic offer_edge(int slot, longint value, longint cur, gbox_t key);
      longint sep;
      sep = labs(value - cur);
      if (sep >= snap_d) return;
      if (pick_found[slot] && (sep > pick_dist[slot] ||
          (sep == pick_dist[slot] && !key_earlier(key, pick_key[slot])))) return;
      pick_found[slot] = 1'b1;
      pick_dist[slot] = sep;
      pick_val[slot] = value;
      pick_key[slot] = key;
   endtask

   function automatic longint pull_inside(longint pos, longint len, longint lo,
                                          longint ext);
      bit hit;
      longint bd, v, sep;
      hit = 1'b0;
      bd = 0;
      v = pos;
      if (pos > lo && pos - lo < snap_d) begin
         hit = 1'b1;
         bd = pos - lo;
         v = lo;
      end
      sep = labs((lo + ext) - (pos + len));
      if (sep < snap_d && (!hit || sep < bd)) v = lo + ext - len;
      return v;
   endfunction

   task automatic predict_snap(drag_item_t it);
      gbox_t ib, g;
      longint ox, oy, ow, oh, rw, rh, mnx, mny, mxx, mxy, orr, ob, gr, gb;
      snap_box_t r;
      ib.x = longint'($signed(it.x));
      ib.y = longint'($signed(it.y));
      ib.w = longint'(it.w);
      ib.h = longint'(it.h);
      case (it.action)
         ACT_BEGIN: begin_b = ib;
         ACT_CURRENT: begin
            cur_b = ib;
            resize_mode = it.rdrag;
            grown_b = '{ib.x - border, ib.y - border, ib.w + 2 * border,
                        ib.h + 2 * border};
            edges[0] = ib.x != begin_b.x;
            edges[1] = ib.x + ib.w != begin_b.x + begin_b.w;
            edges[2] = ib.y != begin_b.y;
            edges[3] = ib.y + ib.h != begin_b.y + begin_b.h;
            for (int i = 0; i < 4; i++) pick_found[i] = 1'b0;
         end
         ACT_CONTAIN: begin
            if (!resize_mode) begin
               ox = pull_inside(grown_b.x, grown_b.w, ib.x, ib.w);
               oy = pull_inside(grown_b.y, grown_b.h, ib.y, ib.h);
               grown_b.x = ox;
               grown_b.y = oy;
            end else begin
               if (edges[0] && labs(grown_b.x - ib.x) < snap_d) begin
                  grown_b.w += grown_b.x - ib.x;
                  grown_b.x = ib.x;
               end
               if (edges[1] && labs(ib.x + ib.w - grown_b.x - grown_b.w) < snap_d)
                  grown_b.w = ib.x + ib.w - grown_b.x;
               if (edges[2] && labs(grown_b.y - ib.y) < snap_d) begin
                  grown_b.h += grown_b.y - ib.y;
                  grown_b.y = ib.y;
               end
               if (edges[3] && labs(ib.y + ib.h - grown_b.y - grown_b.h) < snap_d)
                  grown_b.h = ib.y + ib.h - grown_b.y;
            end
         end
         ACT_NEIGHBOUR: begin
            ib = '{ib.x - border, ib.y - border, ib.w + 2 * border, ib.h + 2 * border};
            g = grown_b;
            orr = ib.x + ib.w;
            ob = ib.y + ib.h;
            gr = g.x + g.w;
            gb = g.y + g.h;
            if (!resize_mode) begin
               if (g.x > orr && g.x < orr + snap_d) offer_edge(0, orr, g.x, ib);
               else if (gr < ib.x && gr > ib.x - snap_d)
                  offer_edge(0, ib.x - g.w, g.x, ib);
               if (g.y > ob && g.y < ob + snap_d) offer_edge(1, ob, g.y, ib);
               else if (gb < ib.y && gb > ib.y - snap_d)
                  offer_edge(1, ib.y - g.h, g.y, ib);
            end else begin
               if (edges[0] && g.x > orr && g.x < orr + snap_d)
                  offer_edge(0, orr, g.x, ib);
               if (edges[1] && gr < ib.x && gr > ib.x - snap_d)
                  offer_edge(1, ib.x - g.w, g.x, ib);
               if (edges[2] && g.y > ob && g.y < ob + snap_d)
                  offer_edge(2, ob, g.y, ib);
               if (edges[3] && gb < ib.y && gb > ib.y - snap_d)
                  offer_edge(3, ib.y - g.h, g.y, ib);
            end
         end
         ACT_FINISH: begin
            g = grown_b;
            if (!resize_mode) begin
               if (pick_found[0]) g.x = pick_val[0];
               if (pick_found[1]) g.y = pick_val[1];
               ox = g.x + border;
               oy = g.y + border;
               ow = cur_b.w;
               oh = cur_b.h;
            end else if (snap_d == 0 || edges == 0) begin
               ox = cur_b.x;
               oy = cur_b.y;
               ow = cur_b.w;
               oh = cur_b.h;
            end else begin
               if (pick_found[0]) begin
                  g.w += g.x - pick_val[0];
                  g.x = pick_val[0];
               end
               if (pick_found[1]) g.w = pick_val[1] - g.x;
               if (pick_found[2]) begin
                  g.h += g.y - pick_val[2];
                  g.y = pick_val[2];
               end
               if (pick_found[3]) g.h = pick_val[3] - g.y;
               rw = g.w - 2 * border;
               rh = g.h - 2 * border;
               mnx = min_w > (1 << FB) ? min_w : (1 << FB);
               mny = min_h > (1 << FB) ? min_h : (1 << FB);
               mxx = max_w > mnx ? max_w : mnx;
               mxy = max_h > mny ? max_h : mny;
               ow = clampv(rw, mnx, mxx);
               oh = clampv(rh, mny, mxy);
               ox = g.x + border;
               oy = g.y + border;
               if (edges[0] && !edges[1]) ox += rw - ow;
               if (edges[2] && !edges[3]) oy += rh - oh;
            end
            ox = clampv(ox, -HI - 1, HI);
            oy = clampv(oy, -HI - 1, HI);
            ow = clampv(ow, 0, HI);
            oh = clampv(oh, 0, HI);
            r.x = ox[CB-1:0];
            r.y = oy[CB-1:0];
            r.w = ow[CB-2:0];
            r.h = oh[CB-2:0];
            r.moved = ox != cur_b.x || oy != cur_b.y || ow != cur_b.w || oh != cur_b.h;
            expected_boxes.insert(expected_boxes.size(), r);
         end
         default: ;
      endcase
   endtask

   // driver: bursts and gaps
   int gap_left = 0;
   int burst_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_snap('{req_action, req_box_x, req_box_y, req_box_w, req_box_h,
                           req_resize_drag});
            n_items++;
         end
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0 && !hold_sender) begin
               drag_item_t it;
               it = pending_items.pop_front();
               req_valid <= 1'b1;
               req_action <= it.action;
               req_box_x <= it.x;
               req_box_y <= it.y;
               req_box_w <= it.w;
               req_box_h <= it.h;
               req_resize_drag <= it.rdrag;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else req_valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stall pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            snap_box_t e;
            n_results++;
            if (expected_boxes.size() == 0) begin
               errors++;
               $display("%0t: unexpected result x=%0d y=%0d", $time, rsp_out_x, rsp_out_y);
            end else begin
               e = expected_boxes.pop_front();
               if (rsp_moved) n_moved++;
               if (rsp_out_x !== e.x || rsp_out_y !== e.y || rsp_out_w !== e.w ||
                   rsp_out_h !== e.h || rsp_moved !== e.moved) begin
                  errors++;
                  $display("%0t: mismatch expected x=%0d y=%0d w=%0d h=%0d m=%0b",
                           $time, $signed(e.x), $signed(e.y), e.w, e.h, e.moved);
                  $display("%0t:          actual x=%0d y=%0d w=%0d h=%0d m=%0b",
                           $time, rsp_out_x, rsp_out_y, rsp_out_w, rsp_out_h, rsp_moved);
               end
            end
         end
         stall_phase = (stall_phase + 1) % 64;
         if (stall_phase < 24) rsp_ready <= 1'b1;
         else if (stall_phase < 44) rsp_ready <= ($urandom_range(0, 3) != 0);
         else rsp_ready <= ($urandom_range(0, 2) == 0);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, longint val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SNAP_DIST: snap_d = val & 12'hFFF;
         CSR_BORDER:    border = val & 12'hFFF;
         CSR_MIN_W:     min_w = val & 23'h7FFFFF;
         CSR_MIN_H:     min_h = val & 23'h7FFFFF;
         CSR_MAX_W:     max_w = val & 23'h7FFFFF;
         CSR_MAX_H:     max_h = val & 23'h7FFFFF;
         default: ;
      endcase
      // idle with csr_valid low before returning, so back-to-back writes never collide
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_boxes.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic drag_item_t mk(logic [ACT_BITS-1:0] a, longint x, longint y,
                                     longint w, longint h, bit r);
      drag_item_t it;
      it.action = a;
      it.x = x[CB-1:0];
      it.y = y[CB-1:0];
      it.w = w[CB-2:0];
      it.h = h[CB-2:0];
      it.rdrag = r;
      return it;
   endfunction

   function automatic longint near(longint c, int spread);
      return c + $signed($urandom_range(0, 2 * spread)) - spread;
   endfunction

   // one drag with random content, at times with an unknown action or a repeated finish
   task automatic queue_drag();
      longint bx, by, bw, bh, cx, cy, cw, ch;
      int sp;
      bit rz;
      int nn;
      sp = int'(snap_d) + 40;
      rz = $urandom_range(0, 1);
      if ($urandom_range(0, 15) == 0) begin
         bx = $signed($urandom_range(0, 32'hFFFFFF) << 8) >>> 8;
         by = $signed($urandom_range(0, 32'hFFFFFF) << 8) >>> 8;
         bw = $urandom_range(0, 23'h7FFFFF);
         bh = $urandom_range(0, 23'h7FFFFF);
      end else begin
         bx = near(0, 20000);
         by = near(0, 20000);
         bw = $urandom_range(0, 8000);
         bh = $urandom_range(0, 8000);
      end
      if (rz) add_item(mk(ACT_BEGIN, bx, by, bw, bh, 0));
      cx = ($urandom_range(0, 1)) ? bx : near(bx, 300);
      cy = ($urandom_range(0, 1)) ? by : near(by, 300);
      cw = ($urandom_range(0, 1)) ? bw : clampv(near(bw, 300), 0, HI);
      ch = ($urandom_range(0, 1)) ? bh : clampv(near(bh, 300), 0, HI);
      add_item(mk(ACT_CURRENT, cx, cy, cw, ch, rz));
      if ($urandom_range(0, 3) != 0)
         add_item(mk(ACT_CONTAIN, near(cx, sp), near(cy, sp),
            clampv(near(cw + 2 * sp, sp), 0, HI), clampv(near(ch + 2 * sp, sp), 0, HI), 0));
      if ($urandom_range(0, 2) != 0)
         add_item(mk(ACT_CONTAIN, near(cx, sp), near(cy, sp),
            clampv(near(cw, sp), 0, HI), clampv(near(ch, sp), 0, HI), 0));
      nn = $urandom_range(0, 6);
      for (int i = 0; i < nn; i++) begin
         longint nw, nh;
         nw = $urandom_range(0, 3000);
         nh = $urandom_range(0, 3000);
         case ($urandom_range(0, 3))
            0: add_item(mk(ACT_NEIGHBOUR, near(cx - nw, sp), near(cy, sp),
                           nw, nh, $urandom_range(0, 1)));
            1: add_item(mk(ACT_NEIGHBOUR, near(cx + cw, sp), near(cy, sp),
                           nw, nh, $urandom_range(0, 1)));
            2: add_item(mk(ACT_NEIGHBOUR, near(cx, sp), near(cy - nh, sp),
                           nw, nh, $urandom_range(0, 1)));
            default: add_item(mk(ACT_NEIGHBOUR, near(cx, sp),
                                 near(cy + ch, sp), nw, nh, 0));
         endcase
      end
      if ($urandom_range(0, 9) == 0)
         add_item(mk(ACT_BITS'($urandom_range(5, 7)), $urandom, $urandom,
                     $urandom, $urandom, $urandom_range(0, 1)));
      add_item(mk(ACT_FINISH, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(0, 1)));
      if ($urandom_range(0, 7) == 0)
         add_item(mk(ACT_FINISH, 0, 0, 0, 0, 0));
   endtask

   // noise: random actions with full-range fields, after a valid current box
   task automatic queue_noise();
      add_item(mk(ACT_BEGIN, $signed($urandom << 8) >>> 8,
                  $signed($urandom << 8) >>> 8, $urandom, $urandom, 0));
      add_item(mk(ACT_CURRENT, $signed($urandom << 8) >>> 8,
                  $signed($urandom << 8) >>> 8, $urandom, $urandom,
                  $urandom_range(0, 1)));
      repeat ($urandom_range(1, 5))
         add_item(mk(ACT_BITS'($urandom_range(0, 7)), $signed($urandom << 8) >>> 8,
                     $signed($urandom << 8) >>> 8, $urandom, $urandom,
                     $urandom_range(0, 1)));
      add_item(mk(ACT_FINISH, 0, 0, 0, 0, 0));
   endtask

   initial begin
      snap_d = SNAP_DIST_RST;
      border = BORDER_RST;
      min_w = MIN_SIZE_RST;
      min_h = MIN_SIZE_RST;
      max_w = MAX_SIZE_RST;
      max_h = MAX_SIZE_RST;
      resize_mode = 1'b0;
      begin_b = '{0, 0, 0, 0};
      cur_b = begin_b;
      grown_b = begin_b;
      edges = '0;
      for (int i = 0; i < 4; i++) pick_found[i] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every action, tie break, unknown action, repeat finish
      add_item(mk(ACT_BEGIN, 0, 0, 1000, 1000, 0));
      add_item(mk(ACT_CURRENT, 50, 60, 1000, 1000, 0));
      add_item(mk(ACT_CONTAIN, 0, 0, 4000, 4000, 0));
      add_item(mk(ACT_FINISH, 0, 0, 0, 0, 0));
      add_item(mk(ACT_FINISH, 0, 0, 0, 0, 0));
      add_item(mk(ACT_CURRENT, 2000, 2000, 500, 500, 0));
      add_item(mk(ACT_NEIGHBOUR, 1900, 0, 50, 50, 0));
      add_item(mk(ACT_NEIGHBOUR, 1850, 0, 100, 50, 0));
      add_item(mk(ACT_NEIGHBOUR, 2550, 2550, 10, 10, 0));
      add_item(mk(ACT_UNUSED, -1, -1, 23'h7FFFFF, 23'h7FFFFF, 1));
      add_item(mk(ACT_FINISH, 0, 0, 0, 0, 0));
      add_item(mk(ACT_BEGIN, 100, 100, 1000, 1000, 0));
      add_item(mk(ACT_CURRENT, 120, 100, 990, 1010, 1));
      add_item(mk(ACT_CONTAIN, 100, 50, 1200, 1200, 0));
      add_item(mk(ACT_NEIGHBOUR, 0, 1150, 40, 40, 0));
      add_item(mk(ACT_FINISH, 0, 0, 0, 0, 0));
      add_item(mk(ACT_BEGIN, -HI - 1, -HI - 1, HI, HI, 0));
      add_item(mk(ACT_CURRENT, HI, HI, HI, HI, 1));
      add_item(mk(ACT_CONTAIN, HI, HI, HI, HI, 0));
      add_item(mk(ACT_FINISH, 0, 0, 0, 0, 0));
      add_item(mk(ACT_CURRENT, -HI - 1, HI, 0, HI, 0));
      add_item(mk(ACT_CONTAIN, -HI - 1, -HI - 1, HI, 0, 0));
      add_item(mk(ACT_FINISH, 0, 0, 0, 0, 0));
      // sender pauses until every result is back
      wait_drained();

      // random phases over several register settings, extremes included
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin write_reg(CSR_SNAP_DIST, 0); write_reg(CSR_BORDER, 0); end
            1: begin write_reg(CSR_SNAP_DIST, 4095); write_reg(CSR_BORDER, 4095); end
            2: begin
               write_reg(CSR_MIN_W, 0); write_reg(CSR_MIN_H, 23'h7FFFFF);
               write_reg(CSR_MAX_W, 0); write_reg(CSR_MAX_H, 16);
            end
            3: begin
               write_reg(CSR_MIN_W, 23'h7FFFFF); write_reg(CSR_MIN_H, 5);
               write_reg(CSR_MAX_W, 23'h7FFFFF); write_reg(CSR_MAX_H, 23'h7FFFFF);
            end
            default: begin
               write_reg(CSR_SNAP_DIST, $urandom_range(1, 600));
               write_reg(CSR_BORDER, $urandom_range(0, 64));
               write_reg(CSR_MIN_W, $urandom_range(0, 1500));
               write_reg(CSR_MIN_H, $urandom_range(0, 1500));
               write_reg(CSR_MAX_W, $urandom_range(0, 9000));
               write_reg(CSR_MAX_H, $urandom_range(0, 9000));
            end
         endcase
         while (pending_items.size() < 190) begin
            if ($urandom_range(0, 9) == 0) queue_noise();
            else queue_drag();
         end
         wait_drained();
      end

      $display("run covered %0d items and %0d results (%0d moved)", n_items, n_results,
               n_moved);
      $display("over move and resize drags across eight register settings");
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire

/* window_edge_magnet_snap_unit.f */
src/wems_pkg.sv
src/wems_engine.sv
src/window_edge_magnet_snap_unit.sv
tb/window_edge_magnet_snap_unit_tb.sv
